### sv/qfa_pkg.sv
// ----------------------------------------------------------------------------
// qfa_pkg
// Shared types and constants of the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package qfa_pkg;

    localparam int WORD_W        = 32;
    localparam int OP_W          = 4;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GT   = 4'd4,
        OP_GE   = 4'd5,
        OP_LT   = 4'd6,
        OP_LE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FINT = 4'd14,
        OP_TINT = 4'd15
    } op_t;

    // Side data that travels alongside the divider stages.
    typedef struct packed {
        op_t                op;
        logic [WORD_W-1:0]  simple_res;
        logic               cond;
        logic               neg;
        logic               div0;
        logic [WORD_W-1:0]  mul_mag;
    } side_t;

endpackage

### sv/qfa_req_if.sv
// ----------------------------------------------------------------------------
// qfa_req_if
// Request channel: operation code and two raw operands.
// ----------------------------------------------------------------------------
interface qfa_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, operation, operand_a, operand_b, input ready);
    modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

### sv/qfa_rsp_if.sv
// ----------------------------------------------------------------------------
// qfa_rsp_if
// Result channel: raw result, condition bit and divide error flag.
// ----------------------------------------------------------------------------
interface qfa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_raw;
    logic               condition;
    logic               divide_error;

    modport source (output valid, result_raw, condition, divide_error, input ready);
    modport sink   (input valid, result_raw, condition, divide_error, output ready);
endinterface

### sv/qfa_div_pipe.sv
// ----------------------------------------------------------------------------
// qfa_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qfa_div_pipe #(
    parameter int DW = 40
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [DW-1:0]              dividend,
    input  logic [qfa_pkg::WORD_W-1:0] divisor,
    output logic [qfa_pkg::WORD_W-1:0] quotient
);
    import qfa_pkg::*;

    logic [WORD_W-1:0] rem_reg [DW];
    logic [DW-1:0]     dq_reg  [DW];
    logic [WORD_W-1:0] d_reg   [DW];

    genvar i;
    generate
        for (i = 0; i < DW; i++) begin : g_stage
            logic [WORD_W-1:0] rem_in;
            logic [DW-1:0]     dq_in;
            logic [WORD_W-1:0] d_in;
            logic [WORD_W:0]   trial;
            logic              ge;
            logic [WORD_W-1:0] rem_next;
            logic [DW-1:0]     dq_next;

            if (i == 0) begin : g_first
                assign rem_in = '0;
                assign dq_in  = dividend;
                assign d_in   = divisor;
            end else begin : g_rest
                assign rem_in = rem_reg[i-1];
                assign dq_in  = dq_reg[i-1];
                assign d_in   = d_reg[i-1];
            end

            always_comb
            begin
                trial    = {rem_in, dq_in[DW-1]};
                ge       = (trial >= {1'b0, d_in});
                rem_next = ge ? WORD_W'(trial - {1'b0, d_in}) : trial[WORD_W-1:0];
                dq_next  = {dq_in[DW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    dq_reg[i]  <= dq_next;
                    d_reg[i]   <= d_in;
                end
            end
        end
    endgenerate

    assign quotient = dq_reg[DW-1][WORD_W-1:0];
endmodule

### sv/q24_8_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu
// Pipelined signed 32-bit fixed-point ALU with a configurable fraction width.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_ch (operation, operand_a, operand_b) and each
// item yields exactly one result on out_ch (result_raw, condition,
// divide_error), in order. Both channels use valid/ready; an item moves on a
// rising edge where both are high.
// Throughput is one item per cycle while the receiver does not stall. Every
// item, whatever its operation, takes the same path: the edge that accepts
// it loads the input stage, then one divider stage per quotient bit
// (32 + FRACTION_BITS, the multiplier sharing the first one) and one output
// stage follow. The divider pipeline sets the depth.
// When the receiver stalls, the whole pipeline freezes and in_ch.ready
// drops; nothing is lost or repeated, and the held result stays on out_ch.
// Reset clears every stage's valid bit, so out_ch.valid is low after reset
// and the block takes an item in the very first cycle.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu #(
    parameter int FRACTION_BITS = qfa_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    qfa_req_if.sink   in_ch,
    qfa_rsp_if.source out_ch
);
    import qfa_pkg::*;

    localparam int DW    = WORD_W + FRACTION_BITS;
    localparam int DEPTH = DW + 1;   // input stage plus divider stages

    // The pipeline advances whenever the output register is free or drained.
    logic adv;
    assign adv         = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    // Input decode: the cheap operations are finished here.
    logic signed [WORD_W-1:0] a, b;
    logic [WORD_W-1:0]        ua, ub;
    side_t                    side_in;
    logic [WORD_W-1:0]        mag_a_in, mag_b_in;

    assign a  = in_ch.operand_a;
    assign b  = in_ch.operand_b;
    assign ua = in_ch.operand_a;
    assign ub = in_ch.operand_b;

    always_comb
    begin
        side_in            = '0;
        side_in.op         = op_t'(in_ch.operation);
        side_in.neg        = a[WORD_W-1] ^ b[WORD_W-1];
        side_in.div0       = (ub == '0);
        mag_a_in           = a[WORD_W-1] ? WORD_W'(-ua) : ua;
        mag_b_in           = b[WORD_W-1] ? WORD_W'(-ub) : ub;
        case (side_in.op)
            OP_ADD:  side_in.simple_res = ua + ub;
            OP_SUB:  side_in.simple_res = ua - ub;
            OP_GT:   side_in.cond = (a > b);
            OP_GE:   side_in.cond = (a >= b);
            OP_LT:   side_in.cond = (a < b);
            OP_LE:   side_in.cond = (a <= b);
            OP_EQ:   side_in.cond = (a == b);
            OP_NE:   side_in.cond = (a != b);
            OP_MIN:  side_in.simple_res = (a < b) ? ua : ub;
            OP_MAX:  side_in.simple_res = (a >= b) ? ua : ub;
            OP_INC:  side_in.simple_res = ua + WORD_W'(1);
            OP_DEC:  side_in.simple_res = ua - WORD_W'(1);
            OP_FINT: side_in.simple_res = ua << FRACTION_BITS;
            OP_TINT: side_in.simple_res = WORD_W'(a >>> FRACTION_BITS);
            default: side_in.simple_res = '0;
        endcase
    end

    // Stage 0 holds operand magnitudes for the multiplier and divider.
    side_t             side_reg  [DEPTH];
    logic              valid_reg [DEPTH];
    logic [WORD_W-1:0] mag_a_reg, mag_b_reg;

    // Multiply magnitudes in stage 1; keep the wrapped, scaled product.
    logic [2*WORD_W-1:0] prod;
    logic [2*WORD_W-1:0] prod_sh;
    side_t               side1_next;

    always_comb
    begin
        prod               = {{WORD_W{1'b0}}, mag_a_reg} * {{WORD_W{1'b0}}, mag_b_reg};
        prod_sh            = prod >> FRACTION_BITS;
        side1_next         = side_reg[0];
        side1_next.mul_mag = prod_sh[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_ch.valid;
            for (int k = 1; k < DEPTH; k++)
                valid_reg[k] <= valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            mag_a_reg   <= mag_a_in;
            mag_b_reg   <= mag_b_in;
            side_reg[1] <= side1_next;
            for (int k = 2; k < DEPTH; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // The divider's first stage lines up with side stage 1.
    logic [WORD_W-1:0] quot;

    qfa_div_pipe #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .en       (adv),
        .dividend ({mag_a_reg, {FRACTION_BITS{1'b0}}}),
        .divisor  (mag_b_reg),
        .quotient (quot)
    );

    // Output stage: apply signs and pick the result.
    side_t             last;
    logic [WORD_W-1:0] res_next;
    logic              valid_out_reg;
    logic [WORD_W-1:0] res_reg;
    logic              cond_reg;
    logic              derr_reg;

    always_comb
    begin
        last = side_reg[DEPTH-1];
        case (last.op)
            OP_MUL:  res_next = last.neg ? WORD_W'(-last.mul_mag) : last.mul_mag;
            OP_DIV:  res_next = last.div0 ? '0 : (last.neg ? WORD_W'(-quot) : quot);
            default: res_next = last.simple_res;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_out_reg <= 1'b0;
        else if (adv)
            valid_out_reg <= valid_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg  <= res_next;
            cond_reg <= last.cond;
            derr_reg <= (last.op == OP_DIV) && last.div0;
        end
    end

    assign out_ch.valid        = valid_out_reg;
    assign out_ch.result_raw   = res_reg;
    assign out_ch.condition    = cond_reg;
    assign out_ch.divide_error = derr_reg;

    // A divide error always carries a zero result and no condition.
    a_derr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.divide_error |-> out_ch.result_raw == '0 && !out_ch.condition)
        else $error("divide error with nonzero result");

    // A true condition only comes from a comparison, whose result is zero.
    a_cond_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.condition |-> out_ch.result_raw == '0)
        else $error("condition set with nonzero result");

    // While stalled, the pipeline's last stage does not move.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg[DEPTH-1]))
        else $error("pipeline moved during stall");
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q24.8 fixed-point ALU. Items are sent through
// the request interface, a behavioral predictor computes the expected result
// of each accepted item, and a checker compares every returned item field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;

    import qfa_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    // Cycles from the accepting edge to the output register.
    localparam int LATENCY = 33 + FRAC;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] result_raw;
        logic        condition;
        logic        divide_error;
    } alu_result_t;

    logic clk;
    logic rst_n;

    qfa_req_if req_ch ();
    qfa_rsp_if rsp_ch ();

    q24_8_fixed_point_alu #(.FRACTION_BITS(FRAC)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch.sink),
        .out_ch (rsp_ch.source)
    );

    alu_result_t pending_results[$];
    int          error_count;
    int          cycle_count;
    // Percentages of cycles on which each side idles; zero gives full speed.
    int          send_idle_pct;
    int          recv_idle_pct;
    // When set, the receiver holds ready low for a long stretch.
    bit          recv_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Magnitude of a signed word, as 64 bits so that the most negative value
    // stays exact.
    function automatic logic [63:0] magnitude_of(logic signed [31:0] v);
        logic signed [63:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    // Predicts the single result of one operation.
    function automatic alu_result_t alu_predict(op_t op, logic signed [31:0] a,
                                                logic signed [31:0] b);
        alu_result_t r;
        logic        neg;
        logic [63:0] mag;
        r   = '{32'd0, 1'b0, 1'b0};
        neg = a[31] ^ b[31];
        case (op)
            OP_ADD: r.result_raw = a + b;
            OP_SUB: r.result_raw = a - b;
            OP_MUL:
            begin
                // Truncate the magnitude, then restore the sign: that rounds
                // toward zero.
                mag = (magnitude_of(a) * magnitude_of(b)) >> FRAC;
                r.result_raw = neg ? 32'(-mag) : 32'(mag);
            end
            OP_DIV:
            begin
                if (b == 0)
                    r.divide_error = 1'b1;
                else
                begin
                    mag = (magnitude_of(a) << FRAC) / magnitude_of(b);
                    r.result_raw = neg ? 32'(-mag) : 32'(mag);
                end
            end
            OP_GT: r.condition = a > b;
            OP_GE: r.condition = a >= b;
            OP_LT: r.condition = a < b;
            OP_LE: r.condition = a <= b;
            OP_EQ: r.condition = a == b;
            OP_NE: r.condition = a != b;
            OP_MIN: r.result_raw = (a < b) ? a : b;
            OP_MAX: r.result_raw = (a >= b) ? a : b;
            OP_INC: r.result_raw = a + 32'd1;
            OP_DEC: r.result_raw = a - 32'd1;
            OP_FINT: r.result_raw = a << FRAC;
            default: r.result_raw = a >>> FRAC;
        endcase
        return r;
    endfunction

    // Sends one item: waits a random idle gap, offers it, and waits for the
    // handshake. The expected result is queued at the accepting edge.
    task automatic send_item(op_t op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(alu_predict(op, a, b));
    endtask

    // Lowers valid after the last item of a phase.
    task automatic stop_sending();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Operands that exercise the signs, the word edges and the fraction
    // boundary.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9, 0))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0100;
            5: return 32'hFFFF_FF00;
            6: return 32'($signed($urandom_range(4096, 0)) - 2048);
            7: return $urandom() >> $urandom_range(31, 0);
            default: return $urandom();
        endcase
    endfunction

    // Directed part: every operation on extreme operands, plus the divide by
    // zero, the wrapping overflows and the rounding of the conversions.
    task automatic test_directed();
        op_t op;
        for (int i = 0; i < 16; i++)
        begin
            op = op_t'(i);
            send_item(op, 32'h8000_0000, 32'h7FFF_FFFF);
        end
        send_item(OP_DIV, 32'h0000_0300, 32'd0);
        send_item(OP_DIV, 32'h8000_0000, 32'hFFFF_FF00);
        send_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_item(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001);
        send_item(OP_FINT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_TINT, 32'hFFFF_FF01, 32'd0);
        send_item(OP_INC, 32'h7FFF_FFFF, 32'd0);
        send_item(OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_MAX, 32'h0000_0005, 32'h0000_0005);
        stop_sending();
        // The sender pauses here until every expected result has come back.
        wait_for_drain();
    endtask

    task automatic test_random(int count);
        op_t op;
        for (int i = 0; i < count; i++)
        begin
            op = op_t'($urandom_range(15, 0));
            send_item(op, pick_operand(), pick_operand());
        end
        stop_sending();
    endtask

    // The receiver stalls for a long stretch while items keep coming, so the
    // pipeline fills and the request side backs up.
    task automatic test_backpressure();
        recv_hold_req = 1'b1;
        send_idle_pct = 0;
        test_random(3 * LATENCY);
        wait_for_drain();
    endtask

    initial
    begin
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_ADD;
        req_ch.operand_a <= '0;
        req_ch.operand_b <= '0;
        send_idle_pct = 34;
        recv_idle_pct = 34;
        recv_hold_req = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        test_directed();
        test_random(600);
        // A stretch with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);
        test_backpressure();
        send_idle_pct = 34;
        recv_idle_pct = 34;
        test_random(400);
        wait_for_drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver ready: random idling, or a long hold counted here when asked.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (4 * LATENCY) @(posedge clk);
                recv_hold_req = 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Checks every accepted result against the oldest expected one.
    initial
    begin
        alu_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result_raw: unexpected item, actual %h", rsp_ch.result_raw);
                    error_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (rsp_ch.result_raw !== exp_r.result_raw)
                    begin
                        $error("result_raw: expected %h actual %h",
                               exp_r.result_raw, rsp_ch.result_raw);
                        error_count++;
                    end
                    if (rsp_ch.condition !== exp_r.condition)
                    begin
                        $error("condition: expected %b actual %b",
                               exp_r.condition, rsp_ch.condition);
                        error_count++;
                    end
                    if (rsp_ch.divide_error !== exp_r.divide_error)
                    begin
                        $error("divide_error: expected %b actual %b",
                               exp_r.divide_error, rsp_ch.divide_error);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
